>>> rtl/core/ssa_pkg.sv
// shared constants and types of the shelf atlas slot allocator
package ssa_pkg;

    localparam int MAX_SHELVES = 256;
    localparam int IDX_W       = $clog2(MAX_SHELVES);
    localparam int CNT_W       = $clog2(MAX_SHELVES + 1);
    localparam int REG_W       = 15;
    localparam int COORD_W     = 14;

    localparam logic [REG_W-1:0] ATLAS_WIDTH_RESET  = REG_W'(1024);
    localparam logic [REG_W-1:0] ATLAS_HEIGHT_RESET = REG_W'(1024);

    // configuration register indexes
    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    typedef struct packed {
        logic [REG_W-1:0] top;
        logic [REG_W-1:0] span;
        logic [REG_W-1:0] cursor;
    } shelf_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/shelf_atlas_slot_allocator_core.sv
// shelf packing slot allocator for a 2d texture atlas, best height fit
//
// usage
//   s_ channel: one beat is one rectangle request (width, height in pixels)
//   m_ channel: one beat per request: placed flag and the slot's x and y
//   cfg port:   cfg_we with cfg_index 0 writes atlas_width, 1 writes atlas_height;
//               write only while no request is in flight
// timing
//   a request scans every stored shelf, one shelf table entry per cycle over the
//   single read port of the shelf memory; a new request is accepted only after the
//   previous one has passed scan, drain, decide and out (an empty table skips scan and drain)
//   the decision is registered and then loaded into the result register in the out
//   state; the next request is taken while that result still waits on m_tready
// reset
//   aresetn (synchronous, active low) empties the shelf table by clearing the
//   shelf count; entries above the count are never read, so the memory itself
//   needs no clearing pass; both atlas registers return to 1024
// stall
//   while m_tvalid is high and m_tready low, a finished result holds its beat
//   and the next request waits in the output stage until the register frees
module shelf_atlas_slot_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] rect_width, [29:15] rect_height, [31:30] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] placed, [14:1] slot_x, [28:15] slot_y, [31:29] zero
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata
);

    localparam int RW = ssa_pkg::REG_W;
    localparam int CW = ssa_pkg::COORD_W;
    localparam int IW = ssa_pkg::IDX_W;
    localparam int NW = ssa_pkg::CNT_W;

    // shelf table: top, span and cursor of each shelf in one word
    ssa_pkg::shelf_entry_t shelf_mem [ssa_pkg::MAX_SHELVES];
    ssa_pkg::shelf_entry_t rd_data_reg;

    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    ssa_pkg::shelf_entry_t wr_data;

    ssa_pkg::state_t state_reg, state_next;

    logic [RW-1:0] atlas_w_reg, atlas_h_reg;
    logic [NW-1:0] count_reg, count_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_pend_reg, rd_pend_next;

    // request and best candidate so far
    logic [RW-1:0] req_h_reg, req_h_next;
    logic [RW:0]   slot_w_reg, slot_w_next;
    logic [RW:0]   slot_h_reg, slot_h_next;
    logic [RW:0]   best_span_reg, best_span_next;
    logic [RW-1:0] best_top_reg, best_top_next;
    logic [RW-1:0] best_cur_reg, best_cur_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic          found_reg, found_next;

    // bottom edge of the last shelf opened
    logic [RW-1:0] last_top_reg, last_top_next;
    logic [RW-1:0] last_span_reg, last_span_next;

    // decided result waiting for the output register
    logic          res_ok_reg, res_ok_next;
    logic [CW-1:0] res_x_reg, res_x_next;
    logic [CW-1:0] res_y_reg, res_y_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    // candidate test on the entry that came out of memory
    logic [RW+1:0] cand_end;
    logic          cand_fit;
    logic [RW:0]   next_y;
    logic [RW+1:0] next_bottom;
    logic          new_fail;
    logic [RW:0]   adv_cursor;

    assign cand_end = {2'b00, rd_data_reg.cursor} + {1'b0, slot_w_reg};
    assign cand_fit = (rd_data_reg.span >= req_h_reg) &&
                      (cand_end <= {2'b00, atlas_w_reg}) &&
                      ({1'b0, rd_data_reg.span} < best_span_reg);

    assign next_y      = (count_reg == '0) ? '0
                         : ({1'b0, last_top_reg} + {1'b0, last_span_reg});
    assign next_bottom = {1'b0, next_y} + {1'b0, slot_h_reg};
    assign new_fail    = (count_reg >= NW'(ssa_pkg::MAX_SHELVES)) ||
                         (next_bottom > {2'b00, atlas_h_reg}) ||
                         (slot_w_reg > {1'b0, atlas_w_reg});
    assign adv_cursor  = {1'b0, best_cur_reg} + slot_w_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        req_h_next     = req_h_reg;
        slot_w_next    = slot_w_reg;
        slot_h_next    = slot_h_reg;
        best_span_next = best_span_reg;
        best_top_next  = best_top_reg;
        best_cur_next  = best_cur_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        last_top_next  = last_top_reg;
        last_span_next = last_span_reg;
        res_ok_next    = res_ok_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = best_idx_reg;
        wr_data        = '{top: best_top_reg, span: best_span_reg[RW-1:0],
                           cursor: adv_cursor[RW-1:0]};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // fold in the entry read last cycle
        if (rd_pend_reg && cand_fit) begin
            best_span_next = {1'b0, rd_data_reg.span};
            best_top_next  = rd_data_reg.top;
            best_cur_next  = rd_data_reg.cursor;
            best_idx_next  = rd_idx_reg;
            found_next     = 1'b1;
        end

        case (state_reg)
            ssa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_h_next     = s_tdata[2*RW-1:RW];
                    slot_w_next    = {1'b0, s_tdata[RW-1:0]} + (RW+1)'(1);
                    slot_h_next    = {1'b0, s_tdata[2*RW-1:RW]} + (RW+1)'(1);
                    best_span_next = {1'b0, atlas_h_reg} + (RW+1)'(1);
                    found_next     = 1'b0;
                    idx_next       = '0;
                    state_next     = (count_reg == '0) ? ssa_pkg::ST_DECIDE
                                                       : ssa_pkg::ST_SCAN;
                end
            end
            ssa_pkg::ST_SCAN: begin
                rd_en        = 1'b1;
                rd_idx_next  = idx_reg[IW-1:0];
                rd_pend_next = 1'b1;
                idx_next     = idx_reg + NW'(1);
                if (idx_reg == count_reg - NW'(1)) begin
                    state_next = ssa_pkg::ST_DRAIN;
                end
            end
            ssa_pkg::ST_DRAIN: begin
                state_next = ssa_pkg::ST_DECIDE;
            end
            ssa_pkg::ST_DECIDE: begin
                if (found_reg) begin
                    // advance the chosen shelf's cursor
                    wr_en       = 1'b1;
                    res_ok_next = 1'b1;
                    res_x_next  = best_cur_reg[CW-1:0];
                    res_y_next  = best_top_reg[CW-1:0];
                end else if (new_fail) begin
                    res_ok_next = 1'b0;
                    res_x_next  = '0;
                    res_y_next  = '0;
                end else begin
                    // open a shelf below the last one
                    wr_en          = 1'b1;
                    wr_addr        = count_reg[IW-1:0];
                    wr_data        = '{top: next_y[RW-1:0], span: slot_h_reg[RW-1:0],
                                       cursor: slot_w_reg[RW-1:0]};
                    count_next     = count_reg + NW'(1);
                    last_top_next  = next_y[RW-1:0];
                    last_span_next = slot_h_reg[RW-1:0];
                    res_ok_next    = 1'b1;
                    res_x_next     = '0;
                    res_y_next     = next_y[CW-1:0];
                end
                state_next = ssa_pkg::ST_OUT;
            end
            ssa_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_y_reg, res_x_reg, res_ok_reg};
                    state_next    = ssa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssa_pkg::ST_IDLE;
            end
        endcase
    end

    // shelf memory, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            shelf_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= shelf_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssa_pkg::ST_IDLE;
            count_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            atlas_w_reg  <= ssa_pkg::ATLAS_WIDTH_RESET;
            atlas_h_reg  <= ssa_pkg::ATLAS_HEIGHT_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    ssa_pkg::CFG_ATLAS_WIDTH:  atlas_w_reg <= cfg_wdata;
                    ssa_pkg::CFG_ATLAS_HEIGHT: atlas_h_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        rd_idx_reg    <= rd_idx_next;
        req_h_reg     <= req_h_next;
        slot_w_reg    <= slot_w_next;
        slot_h_reg    <= slot_h_next;
        best_span_reg <= best_span_next;
        best_top_reg  <= best_top_next;
        best_cur_reg  <= best_cur_next;
        best_idx_reg  <= best_idx_next;
        found_reg     <= found_next;
        last_top_reg  <= last_top_next;
        last_span_reg <= last_span_next;
        res_ok_reg    <= res_ok_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
